// ===== rtl/imp_pkg.sv =====
package imp_pkg;

	localparam int PHASE_FRAC  = 8;
	localparam int ANGLE_ITERS = 18;
	localparam int ACC_FRAC    = 20;
	localparam int TAB_LEN     = 24;
	localparam int ANGLE_STEPS = (ANGLE_ITERS < TAB_LEN) ? ANGLE_ITERS : TAB_LEN;
	localparam int ROOT_STEPS  = 24;
	localparam int DIV_STEPS   = 53;
	localparam int CNT_W       = 6;
	localparam int K_W         = 5;
	localparam int FULL_TURN   = 360 << PHASE_FRAC;
	localparam int PH_W        = $clog2(FULL_TURN);
	localparam int XY_W        = 40;
	localparam int Z_W         = 31;
	localparam int ROUND_SH    = ACC_FRAC - PHASE_FRAC;

	localparam logic [23:0] CAL_IMP_RESET = 24'd1000;
	localparam logic [43:0] IMP_MAX       = '1;

	localparam logic CMD_MEASURE   = 1'b0;
	localparam logic CMD_CALIBRATE = 1'b1;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_ZERO  = 2'd1;
	localparam logic [1:0] STAT_UNCAL = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ITER,
		ST_FIN,
		ST_PREP,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic           load;
		logic           iter;
		logic [K_W-1:0] k;
		logic           fin;
		logic           prep;
		logic           div_step;
		logic           emit;
	} cmd_t;

	typedef struct packed {
		logic need_div;
	} sts_t;

	// atan(2^-k) in 2^-20 degree
	function automatic logic [Z_W-1:0] atan_lut(input logic [K_W-1:0] k);
		logic [Z_W-1:0] v;
		case (k)
			5'd0:  v = 31'd47185920;
			5'd1:  v = 31'd27855475;
			5'd2:  v = 31'd14718068;
			5'd3:  v = 31'd7471121;
			5'd4:  v = 31'd3750058;
			5'd5:  v = 31'd1876857;
			5'd6:  v = 31'd938658;
			5'd7:  v = 31'd469357;
			5'd8:  v = 31'd234682;
			5'd9:  v = 31'd117342;
			5'd10: v = 31'd58671;
			5'd11: v = 31'd29335;
			5'd12: v = 31'd14668;
			5'd13: v = 31'd7334;
			5'd14: v = 31'd3667;
			5'd15: v = 31'd1833;
			5'd16: v = 31'd917;
			5'd17: v = 31'd458;
			5'd18: v = 31'd229;
			5'd19: v = 31'd115;
			5'd20: v = 31'd57;
			5'd21: v = 31'd29;
			5'd22: v = 31'd14;
			5'd23: v = 31'd7;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/imp_ctrl.sv =====
module imp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	input  imp_pkg::sts_t sts,
	output imp_pkg::cmd_t cmd
);

	imp_pkg::state_t state_q, state_d;
	logic [imp_pkg::CNT_W-1:0] cnt_q, cnt_d;
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= imp_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		cmd.k    = cnt_q[imp_pkg::K_W-1:0];
		s_tready = 1'b0;
		unique case (state_q)
			imp_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					cnt_d    = '0;
					state_d  = imp_pkg::ST_ITER;
				end
			end
			imp_pkg::ST_ITER: begin
				cmd.iter = 1'b1;
				cnt_d    = cnt_q + 1'b1;
				if (cnt_q == imp_pkg::CNT_W'(imp_pkg::ROOT_STEPS - 1))
					state_d = imp_pkg::ST_FIN;
			end
			imp_pkg::ST_FIN: begin
				cmd.fin = 1'b1;
				state_d = imp_pkg::ST_PREP;
			end
			imp_pkg::ST_PREP: begin
				cmd.prep = 1'b1;
				cnt_d    = '0;
				state_d  = sts.need_div ? imp_pkg::ST_DIV : imp_pkg::ST_DONE;
			end
			imp_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == imp_pkg::CNT_W'(imp_pkg::DIV_STEPS - 1))
					state_d = imp_pkg::ST_DONE;
			end
			imp_pkg::ST_DONE: begin
				// wait for the output register to drain
				if (!out_valid_q || m_tready) begin
					cmd.emit = 1'b1;
					state_d  = imp_pkg::ST_IDLE;
				end
			end
			default: state_d = imp_pkg::ST_IDLE;
		endcase
	end

	assign m_tvalid = out_valid_q;

endmodule

// ===== rtl/imp_dp.sv =====
module imp_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  imp_pkg::cmd_t      cmd,
	output imp_pkg::sts_t      sts,
	input  logic               cal_we,
	input  logic [23:0]        cal_data,
	input  logic               in_command,
	input  logic signed [15:0] in_real,
	input  logic signed [15:0] in_imag,
	output logic [23:0]        magnitude,
	output logic [43:0]        impedance,
	output logic [17:0]        phase,
	output logic [1:0]         status
);

	localparam int XW = imp_pkg::XY_W;
	localparam int ZW = imp_pkg::Z_W;
	localparam int PW = imp_pkg::PH_W;

	logic [23:0] cal_imp_q, ref_mag_q;
	logic [PW-1:0] offset_q;
	logic calibrated_q;

	logic command_q;
	logic signed [15:0] re_q, im_q;
	logic [47:0] v_q, res_q, bit_q;
	logic signed [XW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic [23:0] mag_q;
	logic [PW-1:0] ph_q;
	logic [47:0] prod_q;
	logic [52:0] div_q;
	logic [24:0] rem_q;
	logic [23:0] magnitude_q;
	logic [43:0] impedance_q;
	logic [17:0] phase_q;
	logic [1:0]  status_q;

	// load
	logic signed [31:0] re2, im2;
	logic [31:0] sum;
	logic signed [XW-1:0] xs, ys;
	assign re2 = in_real * in_real;
	assign im2 = in_imag * in_imag;
	assign sum = 32'(re2) + 32'(im2);
	assign xs  = XW'(in_real) <<< imp_pkg::ACC_FRAC;
	assign ys  = XW'(in_imag) <<< imp_pkg::ACC_FRAC;

	// one root step and, while angle_on, one vectoring step
	logic [47:0] trial;
	logic signed [XW-1:0] dx, dy;
	logic [ZW-1:0] atan_k;
	logic angle_on;
	assign trial    = res_q + bit_q;
	assign dx       = x_q >>> cmd.k;
	assign dy       = y_q >>> cmd.k;
	assign atan_k   = imp_pkg::atan_lut(cmd.k);
	assign angle_on = int'(cmd.k) < imp_pkg::ANGLE_STEPS;

	// angle rounding and axis cases
	logic signed [ZW-1:0] zz;
	logic [ZW-1:0] qq;
	logic [PW-1:0] ph_calc;
	always_comb begin
		zz = z_q;
		if (z_q < 0)
			zz = z_q + (ZW'(360) <<< imp_pkg::ACC_FRAC);
		qq = (ZW'(zz) + (ZW'(1) << (imp_pkg::ROUND_SH - 1))) >> imp_pkg::ROUND_SH;
		if (qq >= ZW'(imp_pkg::FULL_TURN))
			qq = qq - ZW'(imp_pkg::FULL_TURN);
		ph_calc = qq[PW-1:0];
		if (re_q == 0 && im_q == 0)
			ph_calc = '0;
		else if (re_q == 0)
			ph_calc = (im_q > 0) ? PW'(90 << imp_pkg::PHASE_FRAC)
					     : PW'(270 << imp_pkg::PHASE_FRAC);
		else if (im_q == 0)
			ph_calc = (re_q > 0) ? '0 : PW'(180 << imp_pkg::PHASE_FRAC);
	end

	// restoring divide step
	logic [25:0] rem_sh;
	logic q_bit;
	assign rem_sh = {rem_q, div_q[52]};
	assign q_bit  = rem_sh >= {2'b00, mag_q};

	logic need;
	assign need = (command_q == imp_pkg::CMD_MEASURE) && calibrated_q && (mag_q != '0);
	assign sts.need_div = need;

	logic signed [PW:0] ph_diff;
	logic [1:0] stat_calc;
	assign ph_diff = $signed({1'b0, ph_q}) - $signed({1'b0, offset_q});
	always_comb begin
		if (command_q == imp_pkg::CMD_CALIBRATE)
			stat_calc = (mag_q == '0) ? imp_pkg::STAT_ZERO : imp_pkg::STAT_OK;
		else if (!calibrated_q)
			stat_calc = imp_pkg::STAT_UNCAL;
		else if (mag_q == '0)
			stat_calc = imp_pkg::STAT_ZERO;
		else
			stat_calc = imp_pkg::STAT_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_imp_q    <= imp_pkg::CAL_IMP_RESET;
			ref_mag_q    <= '0;
			offset_q     <= '0;
			calibrated_q <= 1'b0;
		end else begin
			if (cal_we)
				cal_imp_q <= cal_data;
			if (cmd.emit && command_q == imp_pkg::CMD_CALIBRATE && mag_q != '0) begin
				ref_mag_q    <= mag_q;
				offset_q     <= ph_q;
				calibrated_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			command_q <= in_command;
			re_q      <= in_real;
			im_q      <= in_imag;
			v_q       <= {sum, 16'd0};
			res_q     <= '0;
			bit_q     <= 48'd1 << 46;
			if (in_real < 0) begin
				x_q <= -xs;
				y_q <= -ys;
				z_q <= ZW'(180) <<< imp_pkg::ACC_FRAC;
			end else begin
				x_q <= xs;
				y_q <= ys;
				z_q <= '0;
			end
		end
		if (cmd.iter) begin
			if (v_q >= trial) begin
				v_q   <= v_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
			if (angle_on) begin
				if (y_q > 0) begin
					x_q <= x_q + dy;
					y_q <= y_q - dx;
					z_q <= z_q + $signed(atan_k);
				end else begin
					x_q <= x_q - dy;
					y_q <= y_q + dx;
					z_q <= z_q - $signed(atan_k);
				end
			end
		end
		if (cmd.fin) begin
			mag_q  <= res_q[23:0];
			ph_q   <= ph_calc;
			prod_q <= cal_imp_q * ref_mag_q;
		end
		if (cmd.prep) begin
			div_q <= 53'({prod_q, 4'd0}) + 53'(mag_q >> 1);
			rem_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= q_bit ? 25'(rem_sh - {2'b00, mag_q}) : rem_sh[24:0];
			div_q <= {div_q[51:0], q_bit};
		end
		if (cmd.emit) begin
			magnitude_q <= mag_q;
			if (!need)
				impedance_q <= '0;
			else if (div_q > 53'(imp_pkg::IMP_MAX))
				impedance_q <= imp_pkg::IMP_MAX;
			else
				impedance_q <= div_q[43:0];
			phase_q  <= (command_q == imp_pkg::CMD_CALIBRATE) ? 18'(ph_q) : 18'(ph_diff);
			status_q <= stat_calc;
		end
	end

	assign magnitude = magnitude_q;
	assign impedance = impedance_q;
	assign phase     = phase_q;
	assign status    = status_q;

endmodule

// ===== rtl/impedance_magnitude_phase_core.sv =====
// channel  | dir | tdata (low bit first)                     | tuser
// s_axis   | in  | re_value[15:0], imag_part[15:0]           | command
// m_axis   | out | magnitude[23:0], impedance[43:0],         | status[1:0]
//          |     | phase[17:0], 2 zero bits                  |
// cfg      | in  | cfg_data: calibration_impedance[23:0]     | -
// one item at a time: accept in idle, 24 root steps (vectoring too below ANGLE_STEPS),
// fin and prep setup, 53 divide steps on a measure with a valid calibration, then
// the done state; the bit-serial divider sets the long case.
// the result sits in an output register, so the next item is taken while
// it waits; a stalled m_tready holds the finished item in the last state.
// arst_n clears the control, the calibration state and sets the register
// to 1000 ohm.
module impedance_magnitude_phase_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // re_value, imag_part
	input  logic        s_tuser,   // command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,   // magnitude, impedance, phase, zero pad
	output logic [1:0]  m_tuser,   // status
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [23:0] cfg_data   // calibration_impedance
);

	imp_pkg::cmd_t cmd;
	imp_pkg::sts_t sts;
	logic [23:0] magnitude;
	logic [43:0] impedance;
	logic [17:0] phase;

	assign cfg_ready = 1'b1;

	imp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	imp_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cal_we     (cfg_valid),
		.cal_data   (cfg_data),
		.in_command (s_tuser),
		.in_real    (s_tdata[15:0]),
		.in_imag    (s_tdata[31:16]),
		.magnitude  (magnitude),
		.impedance  (impedance),
		.phase      (phase),
		.status     (m_tuser)
	);

	assign m_tdata = {2'b00, phase, impedance, magnitude};

endmodule

// ===== rtl/imp_checker.sv =====
module imp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [87:0] m_tdata,
	input logic [1:0]  m_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output item dropped while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in work");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser != imp_pkg::STAT_UNCAL + 2'd1)
		else $error("undefined status code");

	a_no_imp_on_fault: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == imp_pkg::STAT_UNCAL || m_tuser == imp_pkg::STAT_ZERO)
		|-> m_tdata[67:24] == '0)
		else $error("impedance set on a faulted item");

	a_zero_mag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == imp_pkg::STAT_ZERO |-> m_tdata[23:0] == '0)
		else $error("zero magnitude status with nonzero magnitude");

endmodule

bind impedance_magnitude_phase_core imp_checker u_imp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

	localparam logic [31:0] ATAN_DEG20 [24] = '{
		32'd47185920, 32'd27855475, 32'd14718068, 32'd7471121, 32'd3750058, 32'd1876857,
		32'd938658, 32'd469357, 32'd234682, 32'd117342, 32'd58671, 32'd29335,
		32'd14668, 32'd7334, 32'd3667, 32'd1833, 32'd917, 32'd458,
		32'd229, 32'd115, 32'd57, 32'd29, 32'd14, 32'd7
	};
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic [23:0] magnitude;
		logic [43:0] impedance;
		logic [17:0] phase;
		logic [1:0]  status;
	} meas_t;

	class imp_scoreboard;
		logic [23:0] cal_ohms;
		logic [23:0] ref_mag;
		logic [31:0] sys_phase;
		bit          cal_done;
		meas_t       pending[$];
		int          errors;

		function new();
			cal_ohms = 24'd1000;
			ref_mag = '0;
			sys_phase = '0;
			cal_done = 0;
			errors = 0;
		endfunction

		function longint floor_shift(longint v, int s);
			if (v >= 0)
				return v >>> s;
			return -(((-v) - 1) >>> s) - 1;
		endfunction

		function logic [23:0] root_mag(longint r, longint i);
			longint unsigned v, res, b;
			v = longint'(r * r + i * i) << 16;
			res = 0;
			b = 64'd1 << 62;
			while (b > v)
				b >>= 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v -= res + b;
					res = (res >> 1) + b;
				end else begin
					res >>= 1;
				end
				b >>= 2;
			end
			return res[23:0];
		endfunction

		function logic [31:0] angle(longint r, longint i);
			longint x, y, z, dx, dy;
			longint unsigned q;
			if (r == 0 && i == 0)
				return 0;
			if (r == 0)
				return (i > 0 ? 90 : 270) << imp_pkg::PHASE_FRAC;
			if (i == 0)
				return r > 0 ? 0 : (180 << imp_pkg::PHASE_FRAC);
			x = r <<< 20;
			y = i <<< 20;
			z = 0;
			if (x < 0) begin
				x = -x;
				y = -y;
				z = 64'sd180 <<< 20;
			end
			for (int k = 0; k < imp_pkg::ANGLE_STEPS; k++) begin
				dx = floor_shift(x, k);
				dy = floor_shift(y, k);
				if (y > 0) begin
					x += dy;
					y -= dx;
					z += ATAN_DEG20[k];
				end else begin
					x -= dy;
					y += dx;
					z -= ATAN_DEG20[k];
				end
			end
			if (z < 0)
				z += 64'sd360 <<< 20;
			q = (z + (64'd1 << (imp_pkg::ROUND_SH - 1))) >> imp_pkg::ROUND_SH;
			if (q >= imp_pkg::FULL_TURN)
				q -= imp_pkg::FULL_TURN;
			return q[31:0];
		endfunction

		function void note_item(logic cmd, logic [15:0] re, logic [15:0] im);
			meas_t e;
			longint r, i, ph, num;
			r = longint'($signed(re));
			i = longint'($signed(im));
			e.magnitude = root_mag(r, i);
			ph = angle(r, i);
			e.impedance = '0;
			e.status = imp_pkg::STAT_OK;
			if (cmd == imp_pkg::CMD_CALIBRATE) begin
				e.phase = ph[17:0];
				if (e.magnitude == 0) begin
					e.status = imp_pkg::STAT_ZERO;
				end else begin
					ref_mag = e.magnitude;
					sys_phase = ph[31:0];
					cal_done = 1;
				end
			end else begin
				e.phase = 18'(ph - longint'(sys_phase));
				if (!cal_done) begin
					e.status = imp_pkg::STAT_UNCAL;
				end else if (e.magnitude == 0) begin
					e.status = imp_pkg::STAT_ZERO;
				end else begin
					num = longint'(cal_ohms) * longint'(ref_mag) * 16;
					num = (num + e.magnitude / 2) / e.magnitude;
					e.impedance = (num > longint'(imp_pkg::IMP_MAX)) ?
						imp_pkg::IMP_MAX : num[43:0];
				end
			end
			pending.push_back(e);
		endfunction

		task report(string what, logic [63:0] got, logic [63:0] want);
			$display("mismatch %s: got %0h expected %0h", what, got, want);
			errors++;
		endtask

		task check_result(logic [87:0] data, logic [1:0] user);
			meas_t e;
			if (pending.size() == 0) begin
				report("unexpected item", data[63:0], 0);
				return;
			end
			e = pending.pop_front();
			if (data[23:0] !== e.magnitude) report("magnitude", data[23:0], e.magnitude);
			if (data[67:24] !== e.impedance) report("impedance", data[67:24], e.impedance);
			if (data[85:68] !== e.phase) report("phase", data[85:68], e.phase);
			if (data[87:86] !== 2'b00) report("pad", data[87:86], 0);
			if (user !== e.status) report("status", user, e.status);
		endtask
	endclass

	logic        clk, arst_n;
	logic        s_tvalid, s_tready, s_tuser;
	logic [31:0] s_tdata;
	logic        m_tvalid, m_tready;
	logic [87:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_valid, cfg_ready;
	logic [23:0] cfg_data;

	imp_scoreboard sb;
	int send_idle, recv_idle;
	int cycles = 0;

	impedance_magnitude_phase_core dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// receiver side and scoring
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser);
	end

	always @(negedge clk)
		m_tready <= arst_n && ($urandom_range(99) >= recv_idle);

	task automatic send_item(logic cmd, logic [15:0] re, logic [15:0] im);
		@(negedge clk);
		while ($urandom_range(99) < send_idle)
			@(negedge clk);
		s_tvalid <= 1;
		s_tuser <= cmd;
		s_tdata <= {im, re};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_item(cmd, re, im);
		@(negedge clk);
		s_tvalid <= 0;
	endtask

	task automatic drain_and_write(logic [23:0] ohms);
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (100) @(negedge clk);
		cfg_valid <= 1;
		cfg_data <= ohms;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.cal_ohms = ohms;
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	function automatic logic [15:0] pick_part();
		case ($urandom_range(5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'($urandom_range(8) - 4);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_phase(int n);
		for (int k = 0; k < n; k++) begin
			// calibrations are kept rarer so most items measure
			send_item(($urandom_range(9) == 0) ? imp_pkg::CMD_CALIBRATE : imp_pkg::CMD_MEASURE,
				pick_part(), pick_part());
		end
	endtask

	initial begin
		logic [23:0] ohm_set [5];
		sb = new();
		arst_n = 0;
		s_tvalid = 0;
		s_tuser = 0;
		s_tdata = '0;
		m_tready = 0;
		cfg_valid = 0;
		cfg_data = '0;
		send_idle = 21;
		recv_idle = 86;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: uncalibrated, zero vector, axes, corners
		send_item(imp_pkg::CMD_MEASURE, 16'd100, 16'd50);
		send_item(imp_pkg::CMD_CALIBRATE, 16'd0, 16'd0);
		send_item(imp_pkg::CMD_MEASURE, 16'd0, 16'd0);
		send_item(imp_pkg::CMD_CALIBRATE, 16'd1000, 16'd1000);
		send_item(imp_pkg::CMD_MEASURE, 16'd0, 16'd0);
		send_item(imp_pkg::CMD_MEASURE, 16'd0, 16'd5);
		send_item(imp_pkg::CMD_MEASURE, 16'd0, 16'hfffb);
		send_item(imp_pkg::CMD_MEASURE, 16'd7, 16'd0);
		send_item(imp_pkg::CMD_MEASURE, 16'hfff9, 16'd0);
		send_item(imp_pkg::CMD_MEASURE, 16'h8000, 16'h8000);
		send_item(imp_pkg::CMD_MEASURE, 16'h7fff, 16'h7fff);
		send_item(imp_pkg::CMD_MEASURE, 16'h8000, 16'h7fff);
		send_item(imp_pkg::CMD_MEASURE, 16'h7fff, 16'h8000);
		send_item(imp_pkg::CMD_MEASURE, 16'd1, 16'd0);
		send_item(imp_pkg::CMD_CALIBRATE, 16'h8000, 16'h8000);
		send_item(imp_pkg::CMD_MEASURE, 16'd1, 16'd0);
		send_item(imp_pkg::CMD_MEASURE, 16'hffff, 16'hffff);
		drain_and_write(24'hffffff);
		send_item(imp_pkg::CMD_MEASURE, 16'd1, 16'd0);
		send_item(imp_pkg::CMD_MEASURE, 16'd0, 16'd1);

		ohm_set = '{24'd1, 24'd0, 24'd50, 24'hffffff, 24'd1000};
		for (int p = 0; p < 5; p++) begin
			drain_and_write(ohm_set[p]);
			if (p == 2) begin
				send_idle = 86;
				recv_idle = 21;
			end else if (p == 4) begin
				send_idle = 0;
				recv_idle = 0;
			end
			random_phase(p == 4 ? 500 : 350);
		end

		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (100) @(negedge clk);
		if (sb.errors == 0)
			$display("impedance_magnitude_phase_core test passed");
		else
			$display("impedance_magnitude_phase_core test failed");
		$finish;
	end

	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$display("impedance_magnitude_phase_core test failed");
		$finish;
	end

endmodule
